// ----- design/heap_sort_engine_unit_assert.svh -----
// assertion macros for the sort engine checker
`ifndef HEAP_SORT_ENGINE_UNIT_ASSERT_SVH
`define HEAP_SORT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define HSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/hse_pkg.sv -----
package hse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int SETTLE_W     = $clog2(MAX_ELEMENTS);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         is_last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         final_flag;
    logic                         overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic final_flag;
    logic overflow;
  } ctl_t;

endpackage

// ----- design/hse_cell.sv -----
module hse_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop,
  input  logic                                  in_valid,
  input  logic signed [hse_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                                  nb_valid,
  input  logic signed [hse_pkg::DATA_WIDTH-1:0] nb_value,
  output logic                                  valid,
  output logic signed [hse_pkg::DATA_WIDTH-1:0] value,
  output logic                                  out_valid,
  output logic signed [hse_pkg::DATA_WIDTH-1:0] out_value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      out_valid <= 1'b0;
    end else if (pop) begin
      valid     <= nb_valid;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid && valid;
      if (in_valid) begin
        valid <= 1'b1;
      end
    end
  end

  // keep the smaller word, hand the larger one to the right
  always_ff @(posedge clk) begin
    if (pop) begin
      value <= nb_value;
    end else if (in_valid) begin
      if (!valid) begin
        value <= in_value;
      end else if (in_value > value) begin
        out_value <= in_value;
      end else begin
        out_value <= value;
        value     <= in_value;
      end
    end
  end

endmodule

// ----- design/hse_ctrl.sv -----
module hse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  logic          item_last,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  output hse_pkg::ctl_t ctl
);

  hse_pkg::state_t               state, state_next;
  logic [hse_pkg::CNT_W-1:0]     count, count_next;
  logic [hse_pkg::SETTLE_W-1:0]  settle, settle_next;
  logic                          dropped, dropped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hse_pkg::ST_FILL;
      count   <= '0;
      settle  <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      settle  <= settle_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    settle_next    = settle;
    dropped_next   = dropped;
    item_stall     = 1'b1;
    result_valid   = 1'b0;
    ctl.ins        = 1'b0;
    ctl.pop        = 1'b0;
    ctl.final_flag = (count == hse_pkg::CNT_W'(1));
    ctl.overflow   = dropped;
    unique case (state)
      hse_pkg::ST_FILL: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (count < hse_pkg::CNT_W'(hse_pkg::MAX_ELEMENTS)) begin
            ctl.ins    = 1'b1;
            count_next = count + hse_pkg::CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (item_last) begin
            state_next  = hse_pkg::ST_SETTLE;
            settle_next = hse_pkg::SETTLE_W'(hse_pkg::MAX_ELEMENTS - 1);
          end
        end
      end
      hse_pkg::ST_SETTLE: begin
        if (settle == '0) begin
          state_next = hse_pkg::ST_EMIT;
        end else begin
          settle_next = settle - hse_pkg::SETTLE_W'(1);
        end
      end
      hse_pkg::ST_EMIT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          ctl.pop    = 1'b1;
          count_next = count - hse_pkg::CNT_W'(1);
          if (ctl.final_flag) begin
            state_next   = hse_pkg::ST_FILL;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = hse_pkg::ST_FILL;
      end
    endcase
  end

endmodule

// ----- design/heap_sort_engine_unit.sv -----
// channel   valid          stall          payload
// item      item_valid     item_stall     item   (hse_pkg::item_t)
// result    result_valid   result_stall   result (hse_pkg::result_t)
//
// a set of n words is loaded, then left to settle, then emitted
// each word taken while the row has room enters cell 0 and ripples right one cell per cycle
// the row settles after the last word; words are taken while loading only
// rst is synchronous and empties every cell
// a stalled result holds; the row shifts left only when a result word is taken
module heap_sort_engine_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  hse_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output hse_pkg::result_t result
);

  localparam int N = hse_pkg::MAX_ELEMENTS;

  hse_pkg::ctl_t                         ctl;
  logic                                  pass_valid [0:N];
  logic signed [hse_pkg::DATA_WIDTH-1:0] pass_value [0:N];
  logic                                  hold_valid [0:N];
  logic signed [hse_pkg::DATA_WIDTH-1:0] hold_value [0:N];

  hse_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (item.is_last),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctl          (ctl)
  );

  assign pass_valid[0] = ctl.ins;
  assign pass_value[0] = item.value;
  assign hold_valid[N] = 1'b0;
  assign hold_value[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    hse_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .pop       (ctl.pop),
      .in_valid  (pass_valid[i]),
      .in_value  (pass_value[i]),
      .nb_valid  (hold_valid[i+1]),
      .nb_value  (hold_value[i+1]),
      .valid     (hold_valid[i]),
      .value     (hold_value[i]),
      .out_valid (pass_valid[i+1]),
      .out_value (pass_value[i+1])
    );
  end

  assign result.sorted_value = hold_value[0];
  assign result.final_flag   = ctl.final_flag;
  assign result.overflow     = ctl.overflow;

endmodule

// ----- design/hse_checker.sv -----
`include "heap_sort_engine_unit_assert.svh"

module hse_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input hse_pkg::result_t result
);

  logic                                  take;
  logic                                  take_more;
  logic                                  take_last;
  logic                                  held;
  logic signed [hse_pkg::DATA_WIDTH-1:0] head;
  logic                                  ovf;

  assign take      = result_valid && !result_stall;
  assign take_more = take && !result.final_flag;
  assign take_last = take && result.final_flag;
  assign held      = result_valid && result_stall;
  assign head      = result.sorted_value;
  assign ovf       = result.overflow;

  `HSE_ASSERT_NOW(a_no_load_while_emit, result_valid, item_stall, "item taken during emit")
  `HSE_ASSERT_NEXT(a_result_hold, held, result_valid && $stable(result), "stalled result changed")
  `HSE_ASSERT_NEXT(a_ascending, take_more, result_valid && head >= $past(head), "not ascending")
  `HSE_ASSERT_NEXT(a_overflow_steady, take_more, ovf == $past(ovf), "overflow changed in a set")
  `HSE_ASSERT_NEXT(a_reopen, take_last, !item_stall && !result_valid, "not ready after final")

endmodule

bind heap_sort_engine_unit hse_checker u_hse_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
